// File: rtl/rpn_pkg.sv
// Package for the RPN stack calculator: shared types, character codes and result kinds.
// No dependencies.
package rpn_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 8;
	localparam int unsigned DATA_WIDTH_DEF  = 12;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_Q     = 8'h71;

	typedef enum logic [1:0] {
		KIND_PRINT = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_QUIT  = 2'd2
	} kind_t;

	// Operation handed from the front to the back.
	typedef enum logic [3:0] {
		OP_NONE, OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
		OP_NEG, OP_PRINT, OP_DUP, OP_CLEAR, OP_QUIT, OP_ERROR
	} op_t;

endpackage

// File: rtl/rpn_front.sv
// Front end of the RPN calculator: tokenizes characters into up to two operations.
// Depends on rpn_pkg.
module rpn_front
	import rpn_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_char,
	output logic                  out_valid,
	input  logic                  out_ready,
	output op_t                   out_op0,
	output op_t                   out_op1,
	output logic [DATA_WIDTH-1:0] out_num
);

	logic [DATA_WIDTH-1:0] accum_q;
	logic                  in_num_q, neg_q, minus_q, halted_q;
	logic                  full_q;
	op_t                   op0_q, op1_q;
	logic [DATA_WIDTH-1:0] num_q;

	function automatic op_t classify(input logic [7:0] ch);
		op_t o;
		begin
			case (ch)
				CH_SPACE, CH_TAB, CH_NUL: o = OP_NONE;
				CH_PLUS:  o = OP_ADD;
				CH_STAR:  o = OP_MUL;
				CH_SLASH: o = OP_DIV;
				CH_N:     o = OP_NEG;
				CH_P:     o = OP_PRINT;
				CH_D:     o = OP_DUP;
				CH_C:     o = OP_CLEAR;
				CH_Q:     o = OP_QUIT;
				default:  o = OP_ERROR;
			endcase
			return o;
		end
	endfunction

	logic                  is_dig;
	logic [DATA_WIDTH-1:0] dig;
	logic [DATA_WIDTH-1:0] acc_next;
	logic                  take;

	assign is_dig   = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
	assign dig      = DATA_WIDTH'(in_char - CH_ZERO);
	assign acc_next = DATA_WIDTH'({accum_q, 3'b000}) + DATA_WIDTH'({accum_q, 1'b0}) + dig;
	assign in_ready = !full_q || out_ready;
	assign take     = in_valid && in_ready;
	assign out_valid = full_q;
	assign out_op0  = op0_q;
	assign out_op1  = op1_q;
	assign out_num  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q  <= '0;
			in_num_q <= 1'b0;
			neg_q    <= 1'b0;
			minus_q  <= 1'b0;
			halted_q <= 1'b0;
			full_q   <= 1'b0;
			op0_q    <= OP_NONE;
			op1_q    <= OP_NONE;
			num_q    <= '0;
		end else begin
			if (out_ready)
				full_q <= 1'b0;
			if (take && !halted_q) begin
				op0_q <= OP_NONE;
				op1_q <= OP_NONE;
				full_q <= 1'b0;
				if (minus_q && is_dig) begin
					minus_q <= 1'b0; in_num_q <= 1'b1; neg_q <= 1'b1; accum_q <= dig;
				end else if (in_num_q && is_dig) begin
					accum_q <= acc_next;
				end else if (is_dig) begin
					in_num_q <= 1'b1; neg_q <= 1'b0; accum_q <= dig;
				end else begin
					// Delayed push or subtract, then the character itself.
					if (minus_q || in_num_q) begin
						op0_q  <= minus_q ? OP_SUB : OP_PUSH;
						full_q <= 1'b1;
					end
					num_q    <= neg_q ? DATA_WIDTH'(-accum_q) : accum_q;
					minus_q  <= (in_char == CH_MINUS);
					in_num_q <= 1'b0;
					neg_q    <= 1'b0;
					accum_q  <= '0;
					if (in_char != CH_MINUS && classify(in_char) != OP_NONE) begin
						op1_q  <= classify(in_char);
						full_q <= 1'b1;
						if (classify(in_char) == OP_QUIT)
							halted_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// File: rtl/rpn_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg.
module rpn_divider
	import rpn_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quotient
);

	localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

	logic [DATA_WIDTH-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, neg_q, done_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   shifted;

	assign shifted  = {rem_q, quo_q[DATA_WIDTH-1]};
	assign trial    = shifted - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = neg_q ? DATA_WIDTH'(-quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH);
				neg_q  <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
				rem_q  <= '0;
				quo_q  <= dividend[DATA_WIDTH-1] ? DATA_WIDTH'(-dividend) : dividend;
				dvs_q  <= divisor[DATA_WIDTH-1] ? DATA_WIDTH'(-divisor) : divisor;
			end else if (busy_q) begin
				if (!trial[DATA_WIDTH]) begin
					rem_q <= trial[DATA_WIDTH-1:0];
					quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
				end else begin
					rem_q <= shifted[DATA_WIDTH-1:0];
					quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/rpn_back.sv
// Back end of the RPN calculator: executes operations on the stack and emits results.
// Depends on rpn_pkg and rpn_divider.
module rpn_back
	import rpn_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  op_t                   in_op0,
	input  op_t                   in_op1,
	input  logic [DATA_WIDTH-1:0] in_num,
	output logic                  m_valid,
	input  logic                  m_ready,
	output logic [1:0]            m_kind,
	output logic [DATA_WIDTH-1:0] m_value,
	output logic                  m_last
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_BINOP, ST_DIVWAIT, ST_EMIT
	} state_t;

	state_t                state_q;
	logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
	logic [CW-1:0]         cnt_q;
	op_t                   op_q, op1_q;
	logic                  second_q;
	logic [DATA_WIDTH-1:0] num_q, a_q, b_q;
	logic [1:0]            nres_q;
	logic [1:0]            kind0_q, kind1_q;
	logic [DATA_WIDTH-1:0] val0_q, val1_q;
	logic                  ridx_q;
	logic                  div_start, div_done;
	logic [DATA_WIDTH-1:0] div_quo;
	logic [CW-1:0]         cnt_m1, cnt_m2;

	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign in_ready = (state_q == ST_IDLE);
	assign m_valid  = (state_q == ST_EMIT) && (nres_q != 2'd0);
	assign m_kind   = ridx_q ? kind1_q : kind0_q;
	assign m_value  = ridx_q ? val1_q : val0_q;
	assign m_last   = (nres_q == 2'd1) ? 1'b1 : ridx_q;
	assign div_start = (state_q == ST_BINOP) && (op_q == OP_DIV) && (b_q != '0);

	rpn_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(a_q), .divisor(b_q), .done(div_done), .quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			op_q     <= OP_NONE;
			op1_q    <= OP_NONE;
			second_q <= 1'b0;
			nres_q   <= '0;
			ridx_q   <= 1'b0;
			kind0_q  <= '0;
			kind1_q  <= '0;
			val0_q   <= '0;
			val1_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q     <= in_op0;
						op1_q    <= in_op1;
						num_q    <= in_num;
						second_q <= 1'b0;
						nres_q   <= '0;
						ridx_q   <= 1'b0;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_EXEC;
					case (op_q)
						OP_PUSH: begin
							if (cnt_q < CW'(STACK_DEPTH)) begin
								mem[cnt_q[AW-1:0]] <= num_q;
								cnt_q <= cnt_q + CW'(1);
							end else begin
								if (nres_q == 2'd0) kind0_q <= KIND_ERROR; else kind1_q <= KIND_ERROR;
								if (nres_q == 2'd0) val0_q <= '0; else val1_q <= '0;
								nres_q <= nres_q + 2'd1;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (cnt_q >= CW'(2)) begin
								b_q   <= mem[cnt_m1[AW-1:0]];
								a_q   <= mem[cnt_m2[AW-1:0]];
								cnt_q <= cnt_m2;
							end else begin
								if (nres_q == 2'd0) kind0_q <= KIND_ERROR; else kind1_q <= KIND_ERROR;
								if (nres_q == 2'd0) val0_q <= '0; else val1_q <= '0;
								nres_q <= nres_q + 2'd1;
							end
						end
						OP_NEG: begin
							if (cnt_q != '0)
								mem[cnt_m1[AW-1:0]] <= DATA_WIDTH'(-mem[cnt_m1[AW-1:0]]);
							else begin
								if (nres_q == 2'd0) kind0_q <= KIND_ERROR; else kind1_q <= KIND_ERROR;
								if (nres_q == 2'd0) val0_q <= '0; else val1_q <= '0;
								nres_q <= nres_q + 2'd1;
							end
						end
						OP_PRINT: begin
							if (nres_q == 2'd0) kind0_q <= (cnt_q != '0) ? KIND_PRINT : KIND_ERROR;
							else kind1_q <= (cnt_q != '0) ? KIND_PRINT : KIND_ERROR;
							if (nres_q == 2'd0)
								val0_q <= (cnt_q != '0) ? mem[cnt_m1[AW-1:0]] : '0;
							else
								val1_q <= (cnt_q != '0) ? mem[cnt_m1[AW-1:0]] : '0;
							nres_q <= nres_q + 2'd1;
						end
						OP_DUP: begin
							if (cnt_q != '0 && cnt_q < CW'(STACK_DEPTH)) begin
								mem[cnt_q[AW-1:0]] <= mem[cnt_m1[AW-1:0]];
								cnt_q <= cnt_q + CW'(1);
							end else begin
								if (nres_q == 2'd0) kind0_q <= KIND_ERROR; else kind1_q <= KIND_ERROR;
								if (nres_q == 2'd0) val0_q <= '0; else val1_q <= '0;
								nres_q <= nres_q + 2'd1;
							end
						end
						OP_CLEAR: cnt_q <= '0;
						OP_QUIT, OP_ERROR: begin
							if (nres_q == 2'd0)
								kind0_q <= (op_q == OP_QUIT) ? KIND_QUIT : KIND_ERROR;
							else
								kind1_q <= (op_q == OP_QUIT) ? KIND_QUIT : KIND_ERROR;
							if (nres_q == 2'd0) val0_q <= '0; else val1_q <= '0;
							nres_q <= nres_q + 2'd1;
						end
						default: ;
					endcase
					// Binary operators with enough operands continue in the ALU state.
					if ((op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL || op_q == OP_DIV)
						&& cnt_q >= CW'(2))
						state_q <= ST_BINOP;
					else if (!second_q) begin
						second_q <= 1'b1;
						op_q     <= op1_q;
					end else
						state_q <= ST_EMIT;
				end
				ST_BINOP: begin
					if (op_q == OP_DIV) begin
						if (b_q == '0) begin
							if (nres_q == 2'd0) kind0_q <= KIND_ERROR; else kind1_q <= KIND_ERROR;
							if (nres_q == 2'd0) val0_q <= '0; else val1_q <= '0;
							nres_q  <= nres_q + 2'd1;
							state_q <= second_q ? ST_EMIT : ST_EXEC;
							second_q <= 1'b1;
							op_q     <= op1_q;
						end else
							state_q <= ST_DIVWAIT;
					end else begin
						// Room is guaranteed after popping two.
						op_q  <= OP_PUSH;
						num_q <= (op_q == OP_ADD) ? a_q + b_q :
						         (op_q == OP_SUB) ? a_q - b_q : DATA_WIDTH'(a_q * b_q);
						state_q <= ST_EXEC;
					end
				end
				ST_DIVWAIT: begin
					if (div_done) begin
						op_q    <= OP_PUSH;
						num_q   <= div_quo;
						state_q <= ST_EXEC;
					end
				end
				ST_EMIT: begin
					if (nres_q == 2'd0)
						state_q <= ST_IDLE;
					else if (m_ready) begin
						if (m_last)
							state_q <= ST_IDLE;
						else
							ridx_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH)) else $error("stack count out of range");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVWAIT) else $error("divider done while not waiting");
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid |-> nres_q <= 2'd2) else $error("too many results");
`endif

endmodule

// File: rtl/rpn_stack_calculator.sv
// RPN stack calculator top level: tokenizer front, one-entry queue, stack back end.
// A character's results appear once the back end has executed its operations;
// division sets the worst case through the bit-serial divider (one bit per cycle).
// Digits enter one per cycle; a character that hands operations over holds the back end
// until its results are taken, and a full queue that the back end has not taken stalls input.
// Reset (arst_n low) empties the stack and queue and clears the halt flag at once.
module rpn_stack_calculator
	import rpn_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [7:0] char_code
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata, // [DATA_WIDTH-1:0] value
	output logic [1:0]            m_tuser,  // [1:0] kind
	output logic                  m_tlast
);

	localparam int unsigned TDW = ((DATA_WIDTH + 7) / 8) * 8;

	logic                  q_valid, q_ready;
	op_t                   q_op0, q_op1;
	logic [DATA_WIDTH-1:0] q_num;
	logic [DATA_WIDTH-1:0] value;

	// Front classifies the transaction; its output register is the queue.
	rpn_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_char(s_tdata),
		.out_valid(q_valid), .out_ready(q_ready),
		.out_op0(q_op0), .out_op1(q_op1), .out_num(q_num)
	);

	rpn_back #(.STACK_DEPTH(STACK_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready),
		.in_op0(q_op0), .in_op1(q_op1), .in_num(q_num),
		.m_valid(m_tvalid), .m_ready(m_tready),
		.m_kind(m_tuser), .m_value(value), .m_last(m_tlast)
	);

	// Zero-fill the value up to whole bytes.
	assign m_tdata = TDW'(value);

endmodule

// File: verif/rpn_stack_calculator_test.sv
// Testbench for the RPN stack calculator: character stream in, print/error/quit results out.
// Predicts results with its own behavioral calculator and checks every transaction in order.
// Depends on rpn_pkg and rpn_stack_calculator.
module rpn_stack_calculator_test;
	import rpn_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int W     = DATA_WIDTH_DEF;
	localparam int OUT_W = ((W + 7) / 8) * 8;
	localparam int RANDOM_CHARS = 1700;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		kind_t        kind;
		logic [W-1:0] value;
		logic         last;
	} calc_result_t;

	typedef struct {
		logic [7:0]   ch;
		logic         has_check; // expected results typed in below
		int           n_res;
		calc_result_t r0;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0]       m_tuser;
	logic             m_tlast;

	rpn_stack_calculator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// Calculator state mirrored in the testbench.
	logic [W-1:0] stk [DEPTH];
	int           depth_used;
	logic [W-1:0] accum;
	bit           digits_open, digits_neg, minus_seen, stopped;
	calc_result_t pending_res [$];
	calc_result_t step_res [$];
	int           errors;
	longint       cycles = 0;
	bit           no_idle;
	bit           drive_done;
	int           n_sent;
	string        seq;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	function automatic bit is_num(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	task automatic add_res(kind_t k, logic [W-1:0] v);
		calc_result_t r;
		if (step_res.size() < 2) begin
			r.kind = k;
			r.value = v;
			r.last = 1'b0;
			step_res.push_back(r);
		end
	endtask

	task automatic push_word(logic [W-1:0] v);
		if (depth_used < DEPTH) begin
			stk[depth_used] = v;
			depth_used++;
		end else begin
			add_res(KIND_ERROR, '0);
		end
	endtask

	task automatic arith(logic [7:0] op);
		logic [W-1:0] a, b, r, ma, mb, q;
		if (depth_used < 2) begin
			add_res(KIND_ERROR, '0);
			return;
		end
		b = stk[depth_used-1];
		a = stk[depth_used-2];
		depth_used -= 2;
		case (op)
			CH_SLASH: begin
				if (b == 0) begin
					add_res(KIND_ERROR, '0);
					return;
				end
				ma = a[W-1] ? -a : a;
				mb = b[W-1] ? -b : b;
				q = ma / mb;
				r = (a[W-1] ^ b[W-1]) ? -q : q;
			end
			CH_PLUS:  r = a + b;
			CH_MINUS: r = a - b;
			default:  r = a * b;
		endcase
		push_word(r);
	endtask

	task automatic run_char(logic [7:0] c);
		if (is_num(c)) begin
			digits_open = 1;
			digits_neg = 0;
			accum = W'(c - CH_ZERO);
		end else if (c == CH_MINUS) begin
			minus_seen = 1;
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_NUL) begin
		end else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH) begin
			arith(c);
		end else if (c == CH_N) begin
			if (depth_used > 0) stk[depth_used-1] = -stk[depth_used-1];
			else add_res(KIND_ERROR, '0);
		end else if (c == CH_P) begin
			if (depth_used > 0) add_res(KIND_PRINT, stk[depth_used-1]);
			else add_res(KIND_ERROR, '0);
		end else if (c == CH_D) begin
			if (depth_used > 0 && depth_used < DEPTH) begin
				stk[depth_used] = stk[depth_used-1];
				depth_used++;
			end else begin
				add_res(KIND_ERROR, '0);
			end
		end else if (c == CH_C) begin
			depth_used = 0;
		end else if (c == CH_Q) begin
			add_res(KIND_QUIT, '0);
			stopped = 1;
		end else begin
			add_res(KIND_ERROR, '0);
		end
	endtask

	// Advance the predictor by one character; results land in step_res.
	task automatic calc_char(logic [7:0] c);
		logic [W-1:0] v;
		step_res.delete();
		if (stopped) return;
		if (minus_seen) begin
			minus_seen = 0;
			if (is_num(c)) begin
				digits_open = 1;
				digits_neg = 1;
				accum = W'(c - CH_ZERO);
			end else begin
				arith(CH_MINUS);
				run_char(c);
			end
		end else if (digits_open) begin
			if (is_num(c)) begin
				accum = W'(accum * 10) + W'(c - CH_ZERO);
			end else begin
				v = digits_neg ? -accum : accum;
				digits_open = 0;
				digits_neg = 0;
				accum = '0;
				push_word(v);
				run_char(c);
			end
		end else begin
			run_char(c);
		end
		if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
	endtask

	// Hold the character until accepted, then queue its predicted results.
	task automatic send_char(logic [7:0] c);
		while (!no_idle && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		calc_char(c);
		n_sent++;
		foreach (step_res[i]) pending_res.push_back(step_res[i]);
		@(negedge clk);
	endtask

	// Result side: random stall, compare against the oldest prediction.
	always @(negedge clk) begin
		m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		calc_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result kind=%0d value=%0d last=%0b", $time,
					m_tuser, $signed(m_tdata[W-1:0]), m_tlast);
				errors++;
			end else begin
				exp_r = pending_res.pop_front();
				if (m_tuser !== exp_r.kind || m_tdata[W-1:0] !== exp_r.value ||
					m_tlast !== exp_r.last) begin
					$display("%0t: mismatch expected kind=%0d value=%0d last=%0b,%s",
						$time, exp_r.kind, $signed(exp_r.value), exp_r.last, "");
					$display("%0t:          actual kind=%0d value=%0d last=%0b", $time,
						m_tuser, $signed(m_tdata[W-1:0]), m_tlast);
					errors++;
				end
			end
		end
	end

	// Directed rows: extremes and error codes where the result is obvious.
	function automatic stim_row_t row(logic [7:0] c, bit chk = 0, int n = 0,
		kind_t k = KIND_PRINT, logic [W-1:0] v = '0);
		stim_row_t r;
		r.ch = c;
		r.has_check = chk;
		r.n_res = n;
		r.r0.kind = k;
		r.r0.value = v;
		r.r0.last = 1'b1;
		return r;
	endfunction

	// Random token generator: mostly well-formed expressions.
	task automatic send_token();
		int sel, nd;
		sel = $urandom_range(99);
		if (sel < 40) begin
			if ($urandom_range(3) == 0) send_char(CH_MINUS);
			nd = ($urandom_range(7) == 0) ? $urandom_range(6, 4) : $urandom_range(1, 3);
			repeat (nd) send_char(CH_ZERO + 8'($urandom_range(9)));
			send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
		end else if (sel < 70) begin
			case ($urandom_range(3))
				0: send_char(CH_PLUS);
				1: send_char(CH_MINUS);
				2: send_char(CH_STAR);
				default: send_char(CH_SLASH);
			endcase
		end else if (sel < 88) begin
			case ($urandom_range(4))
				0: send_char(CH_N);
				1, 2: send_char(CH_P);
				3: send_char(CH_D);
				default: send_char($urandom_range(5) == 0 ? CH_C : CH_NUL);
			endcase
		end else begin
			// Noise: any byte except quit, which would stop the run early.
			sel = $urandom_range(255);
			if (sel == CH_Q) sel = 8'hff;
			send_char(8'(sel));
		end
	endtask

	stim_row_t dir [$];

	initial begin
		errors = 0;
		no_idle = 0;
		drive_done = 0;
		n_sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		depth_used = 0;
		accum = '0;
		digits_open = 0;
		digits_neg = 0;
		minus_seen = 0;
		stopped = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		dir = {row(CH_P, 1, 1, KIND_ERROR), row(CH_PLUS, 1, 1, KIND_ERROR),
			row(CH_N, 1, 1, KIND_ERROR), row(CH_D, 1, 1, KIND_ERROR),
			row("2"), row("0"), row("4"), row("7"), row(CH_SPACE),
			row(CH_P, 1, 1, KIND_PRINT, 12'd2047), row(CH_D), row(CH_D),
			row(CH_PLUS), row(CH_P), row(CH_MINUS), row("1"), row(CH_SLASH),
			row(CH_P), row(CH_N), row("0"), row(CH_SLASH),
			row(8'hff, 1, 1, KIND_ERROR), row(CH_C), row(CH_TAB), row(CH_NUL)};
		foreach (dir[i]) begin
			send_char(dir[i].ch);
			if (dir[i].has_check && (step_res.size() != dir[i].n_res ||
				(dir[i].n_res > 0 && step_res[0] != dir[i].r0))) begin
				$display("%0t: directed char %02h expected kind=%0d value=%0d, got %0d results",
					$time, dir[i].ch, dir[i].r0.kind, $signed(dir[i].r0.value),
					step_res.size());
				errors++;
			end
		end
		// Most negative divided by minus one, and overflow of a full stack.
		seq = "-2048 -1/p";
		for (int i = 0; i < seq.len(); i++) send_char(seq[i]);
		seq = "c1 ddddddd d8+p";
		for (int i = 0; i < seq.len(); i++) send_char(seq[i]);

		while (n_sent < RANDOM_CHARS) begin
			no_idle = (n_sent >= 600 && n_sent < 800);
			send_token();
			if ($urandom_range(40) == 0) send_char(CH_C);
		end
		no_idle = 0;
		send_char(CH_P);
		send_char(CH_Q);
		send_char(CH_P); // ignored after quit
		s_tvalid <= 1'b0;
		drive_done = 1;
	end

	initial begin
		wait (drive_done);
		while (pending_res.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
		repeat (60) @(posedge clk);
		if (cycles >= CYCLE_LIMIT) errors++;
		if (errors == 0 && pending_res.size() == 0)
			$display("rpn_stack_calculator test passed");
		else
			$display("rpn_stack_calculator test failed");
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT + 1000);
		$display("rpn_stack_calculator test failed");
		$finish;
	end

endmodule

// File: rpn_stack_calculator.f
rtl/rpn_pkg.sv
rtl/rpn_front.sv
rtl/rpn_divider.sv
rtl/rpn_back.sv
rtl/rpn_stack_calculator.sv
verif/rpn_stack_calculator_test.sv
